[rtl/assert_macros.svh]
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define MBG_ASSERT(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mbg assertion failed");

// consequence must hold in the cycle after the trigger
`define MBG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbg assertion failed");

`endif

[rtl/mbg_pkg.sv]
`timescale 1ns / 1ps
package mbg_pkg;

    localparam int MAX_SIDE   = 32;
    localparam int CELL_COUNT = 1024;
    localparam int COORD_W    = 5;
    localparam int SIDE_W     = 6;
    localparam int IDX_W      = 10;
    localparam int DEPTH_W    = 11;
    localparam int SEED_W     = 16;

    localparam logic [SEED_W-1:0] LFSR_TAP = 16'hB400;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_READ  = 2'd1,
        KIND_BAD   = 2'd2
    } t_kind;

    typedef struct packed {
        logic load;      // latch the input word
        logic sweep;     // wall init / visited clear write
        logic seed;      // push start cell and seed lfsr
        logic lfsr_step;
        logic probe;     // read visited bit of candidate
        logic k_inc;
        logic carve;
        logic pop;
        logic pop_load;
        logic rd_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  sweep_last;
        logic  cand_ok;
        logic  nb_visited;
        logic  k_last;
        logic  depth_one;
        logic  out_free;
    } t_sts;

    // out of range sizes are clamped
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0) r = SIDE_W'(1);
        else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
        return r;
    endfunction

    // probe order r, r+1, r+3, r+2
    function automatic logic [1:0] probe_ofs(input logic [1:0] k);
        logic [1:0] r;
        case (k)
            2'd0:    r = 2'd0;
            2'd1:    r = 2'd1;
            2'd2:    r = 2'd3;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

[rtl/mbg_in_if.sv]
`timescale 1ns / 1ps
interface mbg_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [mbg_pkg::COORD_W-1:0]  cell_x;
    logic [mbg_pkg::COORD_W-1:0]  cell_y;
    logic [mbg_pkg::SEED_W-1:0]   seed;

    modport source (output valid, command, cell_x, cell_y, seed, input ready);
    modport sink (input valid, command, cell_x, cell_y, seed, output ready);
endinterface

[rtl/mbg_out_if.sv]
`timescale 1ns / 1ps
interface mbg_out_if;
    logic valid;
    logic ready;
    logic done_res;
    logic east_wall;
    logic south_wall;
    logic bad_coord;

    modport source (output valid, done_res, east_wall, south_wall, bad_coord, input ready);
    modport sink (input valid, done_res, east_wall, south_wall, bad_coord, output ready);
endinterface

[rtl/maze_backtracker_generator.sv]
`timescale 1ns / 1ps
// channel   dir  fields                                     handshake
// i_in      in   command, cell_x, cell_y, seed              valid/ready
// o_out     out  done_res, east_wall, south_wall, bad_coord valid/ready
// i_cfg     in   i_cfg_idx, i_cfg_data                      i_cfg_we
//
// a read or bad-coordinate word goes through dispatch and finish, one item at a time
// a start sweeps all 1024 cells to set walls and clear visited, then carves
// by stepping the lfsr, probing candidate neighbours and popping the stack,
// bound by the single visited-map read port
// synchronous active-low reset; wall reads before the first start return 0
// a waiting result only stalls the block at the end of the next word
module maze_backtracker_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mbg_in_if.sink                      i_in,
    mbg_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [mbg_pkg::SIDE_W-1:0]  i_cfg_data
);
    mbg_pkg::t_cmd w_cmd;
    mbg_pkg::t_sts w_sts;

    mbg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    mbg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_in.command),
        .i_cell_x    (i_in.cell_x),
        .i_cell_y    (i_in.cell_y),
        .i_seed      (i_in.seed),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_done_res  (o_out.done_res),
        .o_east_wall (o_out.east_wall),
        .o_south_wall(o_out.south_wall),
        .o_bad_coord (o_out.bad_coord),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );
endmodule

[rtl/mbg_ram.sv]
`timescale 1ns / 1ps
module mbg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/mbg_ctrl.sv]
`timescale 1ns / 1ps
module mbg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mbg_pkg::t_sts i_sts,
    output mbg_pkg::t_cmd o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_CLEAR = 10'b0000000100,
        S_SEED  = 10'b0000001000,
        S_STEP  = 10'b0000010000,
        S_PROBE = 10'b0000100000,
        S_PWAIT = 10'b0001000000,
        S_POP   = 10'b0010000000,
        S_POPW  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.kind)
                    mbg_pkg::KIND_START: n_state = S_CLEAR;
                    mbg_pkg::KIND_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) n_state = S_SEED;
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = S_STEP;
            end
            S_STEP: begin
                o_cmd.lfsr_step = 1'b1;
                n_state         = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.cand_ok) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_PWAIT;
                end else if (i_sts.k_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_PWAIT: begin
                if (!i_sts.nb_visited) begin
                    o_cmd.carve = 1'b1;
                    n_state     = S_STEP;
                end else if (i_sts.k_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_PROBE;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = i_sts.depth_one ? S_FIN : S_POPW;
            end
            S_POPW: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_STEP;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[rtl/mbg_dp.sv]
`timescale 1ns / 1ps
module mbg_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [mbg_pkg::SIDE_W-1:0]   i_cfg_data,
    input  logic                         i_command,
    input  logic [mbg_pkg::COORD_W-1:0]  i_cell_x,
    input  logic [mbg_pkg::COORD_W-1:0]  i_cell_y,
    input  logic [mbg_pkg::SEED_W-1:0]   i_seed,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_done_res,
    output logic                         o_east_wall,
    output logic                         o_south_wall,
    output logic                         o_bad_coord,
    input  mbg_pkg::t_cmd                i_cmd,
    output mbg_pkg::t_sts                o_sts
);
    localparam int CW = mbg_pkg::COORD_W;
    localparam int SW = mbg_pkg::SIDE_W;
    localparam int IW = mbg_pkg::IDX_W;
    localparam int DW = mbg_pkg::DEPTH_W;

    logic [SW-1:0]  r_gw, r_gh;
    logic [SW-1:0]  w_eff, h_eff;
    logic [CW-1:0]  r_x, r_y;
    logic [mbg_pkg::SEED_W-1:0] r_seed, r_lfsr, n_lfsr;
    mbg_pkg::t_kind r_kind, n_kind;
    logic [IW-1:0]  r_sweep, r_cur, r_nb;
    logic [DW-1:0]  r_depth;
    logic [1:0]     r_r, r_k, r_dir;
    logic           r_ever;
    logic           r_ov, r_done, r_east, r_south, r_bad;

    logic [CW-1:0]  cx, cy, nx, ny, sx, sy;
    logic [1:0]     dir;
    logic           cand_ok, sw_in, init_e, init_s;
    logic [IW-1:0]  nb, start_idx;

    logic           e_we, s_we, v_we, k_we, e_re, v_re, k_re;
    logic [IW-1:0]  e_waddr, s_waddr, v_waddr, k_waddr, rd_idx, k_raddr;
    logic           e_wdata, s_wdata, v_wdata;
    logic [IW-1:0]  k_wdata;
    logic           e_rdata, s_rdata, v_rdata;
    logic [IW-1:0]  k_rdata;

    assign w_eff     = mbg_pkg::eff_side(r_gw);
    assign h_eff     = mbg_pkg::eff_side(r_gh);
    assign start_idx = {r_y, r_x};
    assign rd_idx    = {r_y, r_x};

    // candidate neighbour of the current cell
    assign cx  = r_cur[CW-1:0];
    assign cy  = r_cur[IW-1:CW];
    assign dir = r_r + mbg_pkg::probe_ofs(r_k);

    always_comb begin
        nx      = cx;
        ny      = cy;
        cand_ok = 1'b0;
        case (dir)
            mbg_pkg::DIR_N: begin
                cand_ok = (cy != '0);
                ny      = cy - CW'(1);
            end
            mbg_pkg::DIR_E: begin
                cand_ok = ({1'b0, cx} + SW'(1)) < w_eff;
                nx      = cx + CW'(1);
            end
            mbg_pkg::DIR_S: begin
                cand_ok = ({1'b0, cy} + SW'(1)) < h_eff;
                ny      = cy + CW'(1);
            end
            default: begin
                cand_ok = (cx != '0);
                nx      = cx - CW'(1);
            end
        endcase
    end
    assign nb = {ny, nx};

    // initial wall pattern of the sweep cell
    assign sx     = r_sweep[CW-1:0];
    assign sy     = r_sweep[IW-1:CW];
    assign sw_in  = ({1'b0, sx} < w_eff) && ({1'b0, sy} < h_eff);
    assign init_e = sw_in && (({1'b0, sx} + SW'(1)) < w_eff);
    assign init_s = sw_in && (({1'b0, sy} + SW'(1)) < h_eff);

    always_comb begin
        n_lfsr = {1'b0, r_lfsr[mbg_pkg::SEED_W-1:1]};
        if (r_lfsr[0]) n_lfsr = n_lfsr ^ mbg_pkg::LFSR_TAP;
    end

    always_comb begin
        if (({1'b0, i_cell_x} >= w_eff) || ({1'b0, i_cell_y} >= h_eff)) begin
            n_kind = mbg_pkg::KIND_BAD;
        end else if (i_command == mbg_pkg::CMD_START) begin
            n_kind = mbg_pkg::KIND_START;
        end else begin
            n_kind = mbg_pkg::KIND_READ;
        end
    end

    // memory ports
    assign e_we    = i_cmd.sweep ||
                     (i_cmd.carve && (r_dir == mbg_pkg::DIR_E || r_dir == mbg_pkg::DIR_W));
    assign e_waddr = i_cmd.sweep ? r_sweep : ((r_dir == mbg_pkg::DIR_E) ? r_cur : r_nb);
    assign e_wdata = i_cmd.sweep ? init_e : 1'b0;
    assign s_we    = i_cmd.sweep ||
                     (i_cmd.carve && (r_dir == mbg_pkg::DIR_S || r_dir == mbg_pkg::DIR_N));
    assign s_waddr = i_cmd.sweep ? r_sweep : ((r_dir == mbg_pkg::DIR_S) ? r_cur : r_nb);
    assign s_wdata = i_cmd.sweep ? init_s : 1'b0;
    assign e_re    = i_cmd.rd_issue;

    assign v_we    = i_cmd.sweep || i_cmd.seed || i_cmd.carve;
    assign v_waddr = i_cmd.sweep ? r_sweep : (i_cmd.seed ? start_idx : r_nb);
    assign v_wdata = !i_cmd.sweep;
    assign v_re    = i_cmd.probe;

    assign k_we    = i_cmd.seed || i_cmd.carve;
    assign k_waddr = i_cmd.seed ? '0 : r_depth[IW-1:0];
    assign k_wdata = i_cmd.seed ? start_idx : r_nb;
    assign k_re    = i_cmd.pop && (r_depth != DW'(1));
    // new top of stack after the pop
    assign k_raddr = IW'(r_depth - DW'(2));

    mbg_ram #(.WIDTH(1), .DEPTH(mbg_pkg::CELL_COUNT)) u_east (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_re(e_re), .i_raddr(rd_idx), .o_rdata(e_rdata)
    );
    mbg_ram #(.WIDTH(1), .DEPTH(mbg_pkg::CELL_COUNT)) u_south (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(e_re), .i_raddr(rd_idx), .o_rdata(s_rdata)
    );
    mbg_ram #(.WIDTH(1), .DEPTH(mbg_pkg::CELL_COUNT)) u_visit (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_re(v_re), .i_raddr(nb), .o_rdata(v_rdata)
    );
    mbg_ram #(.WIDTH(IW), .DEPTH(mbg_pkg::CELL_COUNT)) u_stack (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_waddr), .i_wdata(k_wdata),
        .i_re(k_re), .i_raddr(k_raddr), .o_rdata(k_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_cell_x;
            r_y    <= i_cell_y;
            r_seed <= i_seed;
            r_kind <= n_kind;
        end
        if (i_cmd.probe) begin
            r_nb  <= nb;
            r_dir <= dir;
        end
        if (i_cmd.out_load) begin
            r_done  <= (r_kind == mbg_pkg::KIND_START);
            r_bad   <= (r_kind == mbg_pkg::KIND_BAD);
            r_east  <= (r_kind == mbg_pkg::KIND_READ) && r_ever && e_rdata &&
                       (({1'b0, r_x} + SW'(1)) < w_eff);
            r_south <= (r_kind == mbg_pkg::KIND_READ) && r_ever && s_rdata &&
                       (({1'b0, r_y} + SW'(1)) < h_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw    <= SW'(mbg_pkg::MAX_SIDE);
            r_gh    <= SW'(mbg_pkg::MAX_SIDE);
            r_lfsr  <= mbg_pkg::SEED_W'(1);
            r_depth <= '0;
            r_cur   <= '0;
            r_sweep <= '0;
            r_r     <= '0;
            r_k     <= '0;
            r_ever  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mbg_pkg::CFG_GRID_WIDTH) r_gw <= i_cfg_data;
                if (i_cfg_idx == mbg_pkg::CFG_GRID_HEIGHT) r_gh <= i_cfg_data;
            end
            if (i_cmd.load) r_sweep <= '0;
            else if (i_cmd.sweep) r_sweep <= r_sweep + IW'(1);
            if (i_cmd.seed) begin
                r_lfsr  <= (r_seed == '0) ? mbg_pkg::SEED_W'(1) : r_seed;
                r_depth <= DW'(1);
                r_cur   <= start_idx;
                r_ever  <= 1'b1;
            end
            if (i_cmd.lfsr_step) begin
                r_lfsr <= n_lfsr;
                r_r    <= n_lfsr[1:0];
                r_k    <= '0;
            end
            if (i_cmd.k_inc) r_k <= r_k + 2'd1;
            if (i_cmd.carve) begin
                r_depth <= r_depth + DW'(1);
                r_cur   <= r_nb;
            end
            if (i_cmd.pop) r_depth <= r_depth - DW'(1);
            if (i_cmd.pop_load) r_cur <= k_rdata;
            if (i_cmd.out_load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    assign o_sts.kind       = r_kind;
    assign o_sts.sweep_last = &r_sweep;
    assign o_sts.cand_ok    = cand_ok;
    assign o_sts.nb_visited = v_rdata;
    assign o_sts.k_last     = (r_k == 2'd3);
    assign o_sts.depth_one  = (r_depth == DW'(1));
    assign o_sts.out_free   = !r_ov || i_out_ready;

    assign o_out_valid  = r_ov;
    assign o_done_res   = r_done;
    assign o_east_wall  = r_east;
    assign o_south_wall = r_south;
    assign o_bad_coord  = r_bad;
endmodule

[rtl/mbg_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_done_res,
    input logic i_east_wall,
    input logic i_south_wall,
    input logic i_bad_coord
);
    `MBG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `MBG_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `MBG_ASSERT(a_done_no_walls, i_clk, i_rst_n, !(i_out_valid && i_done_res) || (!i_east_wall && !i_south_wall && !i_bad_coord))
    `MBG_ASSERT(a_bad_alone, i_clk, i_rst_n, !(i_out_valid && i_bad_coord) || (!i_east_wall && !i_south_wall && !i_done_res))
endmodule

bind maze_backtracker_generator mbg_checker u_mbg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_done_res  (o_out.done_res),
    .i_east_wall (o_out.east_wall),
    .i_south_wall(o_out.south_wall),
    .i_bad_coord (o_out.bad_coord)
);
